// File: hw/rtl/nlas_pkg.sv
// ----------------------------------------------------------------------------
// nlas_pkg
// Shared constants and types for the nested list argument splitter.
// ----------------------------------------------------------------------------
package nlas_pkg;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   localparam logic [7:0] OPEN_CHAR_RESET  = 8'd60;
   localparam logic [7:0] CLOSE_CHAR_RESET = 8'd62;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_CLOSE = 2'd1;
   localparam logic [1:0] ST_OPEN  = 2'd2;
   localparam logic [1:0] ST_QUOTE = 2'd3;

   localparam logic CSR_OPEN_CHAR  = 1'b0;
   localparam logic CSR_CLOSE_CHAR = 1'b1;

   typedef struct packed {
      logic [15:0] arg_start;
      logic [15:0] arg_length;
      logic [1:0]  status;
      logic        list_end;
   } rsp_type;

   typedef struct packed {
      logic [7:0] open_char;
      logic [7:0] close_char;
   } delim_type;

endpackage

// File: hw/rtl/nlas_parse.sv
// ----------------------------------------------------------------------------
// nlas_parse
// Parser state and per-character next-state logic; one character per cycle while step is high.
// ----------------------------------------------------------------------------
module nlas_parse import nlas_pkg::*; #(
   parameter int unsigned      MAX_DEPTH = 255,
   parameter int unsigned      DEPTH_W   = 8,
   parameter int unsigned      OFS_W     = 16,
   parameter logic [OFS_W-1:0] OFS_CAP   = '1
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      step,
   input  logic [7:0] char_in,
   input  delim_type delim,
   output logic      emit,
   output rsp_type   result
);

   localparam logic [1:0] MODE_SKIP = 2'd0;
   localparam logic [1:0] MODE_ARG  = 2'd1;
   localparam logic [1:0] MODE_STR  = 2'd2;
   localparam logic [1:0] MODE_ESC  = 2'd3;

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
   localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

   logic [1:0]         mode_ff, mode_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [OFS_W-1:0]   trail_ff, trail_in;
   logic [OFS_W-1:0]   ofs_ff, ofs_in;
   logic [OFS_W-1:0]   start_ff, start_in;
   logic               discard_ff, discard_in;

   logic [OFS_W-1:0] ofs_inc;
   logic [OFS_W-1:0] trail_nxt;
   logic [OFS_W-1:0] span;
   logic [OFS_W-1:0] len;
   logic             tail;
   logic             is_nul;

   always_comb begin
      ofs_inc   = (ofs_ff < OFS_CAP) ? ofs_ff + OFS_W'(1) : ofs_ff;
      trail_nxt = (char_in == CHAR_SPACE) ?
                  ((trail_ff < OFS_CAP) ? trail_ff + OFS_W'(1) : trail_ff) : '0;
      span      = ofs_ff - start_ff;
      if (ofs_ff < start_ff || trail_ff > span) begin
         len = '0;
      end else begin
         len = span - trail_ff;
      end
      is_nul = (char_in == CHAR_NUL);
   end

   always_comb begin
      mode_in    = mode_ff;
      depth_in   = depth_ff;
      trail_in   = trail_ff;
      ofs_in     = ofs_ff;
      start_in   = start_ff;
      discard_in = discard_ff;
      emit       = 1'b0;
      tail       = 1'b0;
      result.arg_start  = 16'(start_ff);
      result.arg_length = 16'd0;
      result.status     = ST_OK;
      result.list_end   = 1'b0;

      if (discard_ff) begin
         if (is_nul) begin
            mode_in    = MODE_SKIP;
            depth_in   = '0;
            trail_in   = '0;
            ofs_in     = '0;
            start_in   = '0;
            discard_in = 1'b0;
         end
      end else begin
         unique case (mode_ff)
            MODE_SKIP: begin
               if (char_in == CHAR_SPACE) begin
                  tail = 1'b1;
               end else if (char_in == CHAR_QUOTE) begin
                  start_in = ofs_ff;
                  mode_in  = MODE_STR;
                  tail     = 1'b1;
               end else if (char_in == CHAR_COMMA) begin
                  emit             = 1'b1;
                  result.arg_start = 16'(ofs_ff);
                  mode_in          = MODE_SKIP;
                  depth_in         = '0;
                  trail_in         = '0;
                  ofs_in           = ofs_inc;
               end else if (is_nul) begin
                  emit             = 1'b1;
                  result.arg_start = 16'(ofs_ff);
                  result.list_end  = 1'b1;
                  mode_in          = MODE_SKIP;
                  depth_in         = '0;
                  trail_in         = '0;
                  ofs_in           = '0;
                  start_in         = '0;
               end else if (char_in == delim.open_char) begin
                  start_in = ofs_ff;
                  depth_in = DEPTH_ONE;
                  mode_in  = MODE_ARG;
                  tail     = 1'b1;
               end else if (char_in == delim.close_char) begin
                  emit             = 1'b1;
                  result.arg_start = 16'(ofs_ff);
                  result.status    = ST_CLOSE;
                  result.list_end  = 1'b1;
                  mode_in          = MODE_SKIP;
                  depth_in         = '0;
                  trail_in         = '0;
                  discard_in       = 1'b1;
               end else begin
                  start_in = ofs_ff;
                  mode_in  = MODE_ARG;
                  tail     = 1'b1;
               end
            end
            MODE_ARG: begin
               if (char_in == CHAR_QUOTE) begin
                  mode_in = MODE_STR;
                  tail    = 1'b1;
               end else if (char_in == CHAR_COMMA || is_nul) begin
                  emit            = 1'b1;
                  result.list_end = is_nul;
                  mode_in         = MODE_SKIP;
                  depth_in        = '0;
                  trail_in        = '0;
                  if (depth_ff != '0) begin
                     result.status   = ST_OPEN;
                     result.list_end = 1'b1;
                     if (is_nul) begin
                        ofs_in   = '0;
                        start_in = '0;
                     end else begin
                        discard_in = 1'b1;
                     end
                  end else begin
                     result.arg_length = 16'(len);
                     if (is_nul) begin
                        ofs_in   = '0;
                        start_in = '0;
                     end else begin
                        ofs_in = ofs_inc;
                     end
                  end
               end else if (char_in == delim.open_char) begin
                  if (depth_ff < DEPTH_MAX) begin
                     depth_in = depth_ff + DEPTH_ONE;
                  end
                  tail = 1'b1;
               end else if (char_in == delim.close_char) begin
                  if (depth_ff == '0) begin
                     emit            = 1'b1;
                     result.status   = ST_CLOSE;
                     result.list_end = 1'b1;
                     mode_in         = MODE_SKIP;
                     trail_in        = '0;
                     discard_in      = 1'b1;
                  end else begin
                     depth_in = depth_ff - DEPTH_ONE;
                     tail     = 1'b1;
                  end
               end else begin
                  tail = 1'b1;
               end
            end
            MODE_STR, MODE_ESC: begin
               if (is_nul) begin
                  emit            = 1'b1;
                  result.status   = ST_QUOTE;
                  result.list_end = 1'b1;
                  mode_in         = MODE_SKIP;
                  depth_in        = '0;
                  trail_in        = '0;
                  ofs_in          = '0;
                  start_in        = '0;
               end else begin
                  tail = 1'b1;
                  if (mode_ff == MODE_ESC) begin
                     mode_in = MODE_STR;
                  end else if (char_in == CHAR_QUOTE) begin
                     mode_in = MODE_ARG;
                  end else if (char_in == CHAR_BACKSLASH) begin
                     mode_in = MODE_ESC;
                  end
               end
            end
            default: begin
               mode_in = MODE_SKIP;
            end
         endcase
      end

      if (tail) begin
         trail_in = trail_nxt;
         ofs_in   = ofs_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_SKIP;
         depth_ff   <= '0;
         trail_ff   <= '0;
         ofs_ff     <= '0;
         start_ff   <= '0;
         discard_ff <= 1'b0;
      end else if (step) begin
         mode_ff    <= mode_in;
         depth_ff   <= depth_in;
         trail_ff   <= trail_in;
         ofs_ff     <= ofs_in;
         start_ff   <= start_in;
         discard_ff <= discard_in;
      end
   end

endmodule

// File: hw/rtl/nested_list_argument_splitter_core.sv
// ----------------------------------------------------------------------------
// nested_list_argument_splitter_core
// Splits a NUL-terminated character stream at top-level commas and reports
// each argument's start offset and trimmed length, with nesting and quotes.
// ----------------------------------------------------------------------------
//  channel  | ports                                  | carries
//  req      | req_valid, req_stall, req_char_in      | one character
//  rsp      | rsp_valid, rsp_stall, rsp_arg_start,   | one argument or error
//           | rsp_arg_length, rsp_status, rsp_list_end|
//  csr      | csr_write_enable, csr_index, csr_write_data | open/close chars
//
//  One character per cycle while the result register is free; each character is
//  held in the input register, then its result in the result register.
//  The parser state advances once per character, when the result register is free.
//  A stalled result holds the input stage; characters without a result pass
//  as soon as the result register is free.
//  Reset is synchronous; it clears all control state and restores the default
//  open and close characters.
// ----------------------------------------------------------------------------
module nested_list_argument_splitter_core import nlas_pkg::*; #(
   parameter longint unsigned MAX_LEN   = 65536,
   parameter int unsigned     MAX_DEPTH = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_arg_start,
   output logic [15:0] rsp_arg_length,
   output logic [1:0]  rsp_status,
   output logic        rsp_list_end,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [7:0]  csr_write_data
);

   localparam int unsigned OFS_W = (MAX_LEN >= 64'd65536) ? 16 : $clog2(MAX_LEN);
   localparam logic [OFS_W-1:0] OFS_CAP =
      (MAX_LEN >= 64'd65536) ? '1 : OFS_W'(MAX_LEN - 64'd1);
   localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);

   delim_type  delim_ff, delim_in;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] char_ff, char_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;
   logic       out_free;
   logic       step;
   logic       emit;
   rsp_type    result;

   always_comb begin
      delim_in = delim_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_OPEN_CHAR:  delim_in.open_char  = csr_write_data;
            CSR_CLOSE_CHAR: delim_in.close_char = csr_write_data;
            default:        delim_in = delim_ff;
         endcase
      end
   end

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      char_in     = char_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         char_in     = req_char_in;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (step && emit) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   nlas_parse #(
      .MAX_DEPTH (MAX_DEPTH),
      .DEPTH_W   (DEPTH_W),
      .OFS_W     (OFS_W),
      .OFS_CAP   (OFS_CAP)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .char_in (char_ff),
      .delim   (delim_ff),
      .emit    (emit),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff.open_char  <= OPEN_CHAR_RESET;
         delim_ff.close_char <= CLOSE_CHAR_RESET;
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
      end else begin
         delim_ff     <= delim_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      out_ff  <= out_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_arg_start  = out_ff.arg_start;
   assign rsp_arg_length = out_ff.arg_length;
   assign rsp_status     = out_ff.status;
   assign rsp_list_end   = out_ff.list_end;

`ifndef NO_ASSERTIONS
   a_err_ends_list: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_list_end && rsp_arg_length == 16'd0)
      else $error("error transaction without list end or with nonzero length");

   a_mid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_list_end |-> rsp_status == ST_OK)
      else $error("non-final transaction carries an error status");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> in_valid_ff && char_ff == $past(req_char_in))
      else $error("accepted transaction not held in input register");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(out_ff))
      else $error("stalled result changed");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the nested list argument splitter against a cycle-free predictor.
// Character strings (directed cases, deep nesting that saturates, and
// random well-formed or broken argument lists) are pushed through the req
// channel under several delimiter settings and idle patterns; every rsp
// transaction is compared field by field with the predicted argument.
// ----------------------------------------------------------------------------
module testbench;
   import nlas_pkg::*;

   localparam longint unsigned MAX_LEN      = 65536;
   localparam int unsigned     MAX_DEPTH    = 255;
   localparam int unsigned     OFFSET_CAP   =
      32'((MAX_LEN - 64'd1 > 64'd65535) ? 64'd65535 : MAX_LEN - 64'd1);
   localparam int unsigned     DRAIN_CYCLES = 4;
   localparam int unsigned     CYCLE_LIMIT  = 200000;
   localparam int unsigned     PHASE_CHARS  = 60;
   localparam int unsigned     NUM_SETTINGS = 7;

   typedef enum logic [1:0] {
      SCAN_SKIP, SCAN_ARG, SCAN_QUOTED, SCAN_ESCAPE
   } scan_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_arg_start;
   logic [15:0] rsp_arg_length;
   logic [1:0]  rsp_status;
   logic        rsp_list_end;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = CSR_OPEN_CHAR;
   logic [7:0]  csr_write_data = 8'h00;

   nested_list_argument_splitter_core #(
      .MAX_LEN   (MAX_LEN),
      .MAX_DEPTH (MAX_DEPTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_in      (req_char_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_arg_start    (rsp_arg_start),
      .rsp_arg_length   (rsp_arg_length),
      .rsp_status       (rsp_status),
      .rsp_list_end     (rsp_list_end),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [7:0]  pending_chars[$];
   rsp_type     expected_args[$];
   int unsigned send_idle_pct = 12;
   int unsigned recv_stall_pct = 77;
   int unsigned chars_sent = 0;
   int unsigned args_checked = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned settings_run = 1;

   // predictor state
   logic [7:0]    open_cfg = OPEN_CHAR_RESET;
   logic [7:0]    close_cfg = CLOSE_CHAR_RESET;
   scan_mode_type scan_mode = SCAN_SKIP;
   int unsigned   depth = 0;
   int unsigned   trail = 0;
   int unsigned   char_off = 0;
   int unsigned   arg_start_off = 0;
   bit            dropping = 1'b0;

   function automatic void queue_result(input int unsigned start, input int unsigned len,
                                        input logic [1:0] st, input logic fin);
      rsp_type r;
      r.arg_start  = start[15:0];
      r.arg_length = len[15:0];
      r.status     = st;
      r.list_end   = fin;
      expected_args.push_back(r);
   endfunction

   function automatic void restart_arg();
      scan_mode = SCAN_SKIP;
      depth     = 0;
      trail     = 0;
   endfunction

   function automatic void restart_string();
      restart_arg();
      char_off      = 0;
      arg_start_off = 0;
      dropping      = 1'b0;
   endfunction

   function automatic void bump_offset();
      if (char_off < OFFSET_CAP) char_off++;
   endfunction

   function automatic void flag_error(input int unsigned start, input logic [1:0] st,
                                      input logic [7:0] ch);
      queue_result(start, 0, st, 1'b1);
      if (ch == CHAR_NUL) begin
         restart_string();
      end else begin
         restart_arg();
         dropping = 1'b1;
      end
   endfunction

   function automatic int unsigned trimmed_len();
      int unsigned span;
      if (char_off < arg_start_off) return 0;
      span = char_off - arg_start_off;
      if (trail > span) return 0;
      return span - trail;
   endfunction

   function automatic void split_char(input logic [7:0] ch);
      if (dropping) begin
         if (ch == CHAR_NUL) restart_string();
         return;
      end
      case (scan_mode)
         SCAN_SKIP: begin
            if (ch != CHAR_SPACE) begin
               if (ch == CHAR_QUOTE) begin
                  arg_start_off = char_off;
                  scan_mode = SCAN_QUOTED;
               end else if (ch == CHAR_COMMA) begin
                  queue_result(char_off, 0, ST_OK, 1'b0);
                  restart_arg();
                  bump_offset();
                  return;
               end else if (ch == CHAR_NUL) begin
                  queue_result(char_off, 0, ST_OK, 1'b1);
                  restart_string();
                  return;
               end else if (ch == open_cfg) begin
                  arg_start_off = char_off;
                  depth = 1;
                  scan_mode = SCAN_ARG;
               end else if (ch == close_cfg) begin
                  flag_error(char_off, ST_CLOSE, ch);
                  return;
               end else begin
                  arg_start_off = char_off;
                  scan_mode = SCAN_ARG;
               end
            end
         end
         SCAN_ARG: begin
            if (ch == CHAR_QUOTE) begin
               scan_mode = SCAN_QUOTED;
            end else if (ch == CHAR_COMMA || ch == CHAR_NUL) begin
               if (depth != 0) begin
                  flag_error(arg_start_off, ST_OPEN, ch);
                  return;
               end
               if (ch == CHAR_NUL) begin
                  queue_result(arg_start_off, trimmed_len(), ST_OK, 1'b1);
                  restart_string();
               end else begin
                  queue_result(arg_start_off, trimmed_len(), ST_OK, 1'b0);
                  restart_arg();
                  bump_offset();
               end
               return;
            end else if (ch == open_cfg) begin
               if (depth < MAX_DEPTH) depth++;
            end else if (ch == close_cfg) begin
               if (depth == 0) begin
                  flag_error(arg_start_off, ST_CLOSE, ch);
                  return;
               end
               depth--;
            end
         end
         SCAN_QUOTED: begin
            if (ch == CHAR_QUOTE) begin
               scan_mode = SCAN_ARG;
            end else if (ch == CHAR_BACKSLASH) begin
               scan_mode = SCAN_ESCAPE;
            end else if (ch == CHAR_NUL) begin
               flag_error(arg_start_off, ST_QUOTE, ch);
               return;
            end
         end
         default: begin
            if (ch == CHAR_NUL) begin
               flag_error(arg_start_off, ST_QUOTE, ch);
               return;
            end
            scan_mode = SCAN_QUOTED;
         end
      endcase
      if (ch == CHAR_SPACE) begin
         if (trail < OFFSET_CAP) trail++;
      end else begin
         trail = 0;
      end
      bump_offset();
   endfunction

   // driver: one character per transaction, with random idle cycles
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            split_char(req_char_in);
            chars_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_chars.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_char_in <= pending_chars.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compares each rsp transaction with the oldest predicted argument
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.arg_start  = rsp_arg_start;
            got.arg_length = rsp_arg_length;
            got.status     = rsp_status;
            got.list_end   = rsp_list_end;
            if (expected_args.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected rsp: start %0d length %0d status %0d end %0b",
                           got.arg_start, got.arg_length, got.status, got.list_end);
               mismatches++;
            end else begin
               want = expected_args.pop_front();
               args_checked++;
               if (got.arg_start !== want.arg_start || got.arg_length !== want.arg_length ||
                   got.status !== want.status || got.list_end !== want.list_end) begin
                  if (mismatches < 10)
                     $display("rsp mismatch: exp start %0d length %0d status %0d end %0b,",
                              want.arg_start, want.arg_length, want.status, want.list_end,
                              " got start %0d length %0d status %0d end %0b",
                              got.arg_start, got.arg_length, got.status, got.list_end);
                  mismatches++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic bit fixed_char(input logic [7:0] b);
      return b inside {CHAR_NUL, CHAR_SPACE, CHAR_QUOTE, CHAR_COMMA, CHAR_BACKSLASH};
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(1, 255));
      if (fixed_char(b) || b == open_cfg || b == close_cfg) b = 8'h61;
      return b;
   endfunction

   function automatic logic [7:0] junk_byte();
      case ($urandom_range(0, 9))
         0: return CHAR_NUL;
         1: return CHAR_SPACE;
         2: return CHAR_QUOTE;
         3: return CHAR_COMMA;
         4: return CHAR_BACKSLASH;
         5: return open_cfg;
         6: return close_cfg;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) pending_chars.push_back(s[i]);
      pending_chars.push_back(CHAR_NUL);
   endfunction

   function automatic void push_run(input logic [7:0] b, input int unsigned n);
      repeat (n) pending_chars.push_back(b);
   endfunction

   function automatic void push_quoted();
      logic [7:0] b;
      pending_chars.push_back(CHAR_QUOTE);
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 3) == 0) begin
            pending_chars.push_back(CHAR_BACKSLASH);
            pending_chars.push_back(8'($urandom_range(1, 255)));
         end else begin
            b = 8'($urandom_range(1, 255));
            if (b == CHAR_QUOTE || b == CHAR_BACKSLASH) b = 8'h61;
            pending_chars.push_back(b);
         end
      end
      pending_chars.push_back(CHAR_QUOTE);
   endfunction

   // mostly well-formed argument lists, the rest random junk
   function automatic void push_random_list();
      int unsigned nargs;
      int unsigned levels;
      int unsigned a;
      bit          can_open;
      bit          can_close;
      can_open  = !fixed_char(open_cfg);
      can_close = !fixed_char(close_cfg) && close_cfg != open_cfg;
      if ($urandom_range(0, 99) < 80) begin
         nargs = $urandom_range(1, 4);
         for (a = 0; a < nargs; a++) begin
            if (a > 0) pending_chars.push_back(CHAR_COMMA);
            push_run(CHAR_SPACE, $urandom_range(0, 2));
            levels = 0;
            repeat ($urandom_range(0, 6)) begin
               case ($urandom_range(0, 9))
                  4: pending_chars.push_back(CHAR_SPACE);
                  5: begin
                     if (can_open) begin
                        pending_chars.push_back(open_cfg);
                        levels++;
                     end else begin
                        pending_chars.push_back(plain_byte());
                     end
                  end
                  6: begin
                     if (levels > 0 && can_close) begin
                        pending_chars.push_back(close_cfg);
                        levels--;
                     end
                  end
                  7: push_quoted();
                  8: if (levels > 0) pending_chars.push_back(CHAR_COMMA);
                  default: pending_chars.push_back(plain_byte());
               endcase
            end
            if (can_close) push_run(close_cfg, levels);
            push_run(CHAR_SPACE, $urandom_range(0, 2));
         end
      end else begin
         repeat ($urandom_range(0, 12)) pending_chars.push_back(junk_byte());
      end
      if ($urandom_range(0, 9) != 0) pending_chars.push_back(CHAR_NUL);
   endfunction

   task automatic wait_drained();
      while (pending_chars.size() != 0 || req_valid || expected_args.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_delims(input logic [7:0] o, input logic [7:0] c);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_OPEN_CHAR;
      csr_write_data   <= o;
      @(posedge clock);
      csr_index        <= CSR_CLOSE_CHAR;
      csr_write_data   <= c;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      open_cfg  = o;
      close_cfg = c;
   endtask

   logic [7:0] open_set[NUM_SETTINGS]  = '{8'h7B, 8'h28, 8'h5B, 8'h00, 8'hFF, 8'h2C, 8'h3C};
   logic [7:0] close_set[NUM_SETTINGS] = '{8'h7D, 8'h29, 8'h5B, 8'hFF, 8'h00, 8'h22, 8'h3E};

   initial begin
      int unsigned k;
      int unsigned phase_start;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty string, empty args, nesting, quotes, errors
      push_text("");
      push_text(" a ,,<b,c> ");
      push_text("\"\\\",\"");
      push_text(">x");
      push_text("a<");
      push_text("\"\\");
      wait_drained();

      for (k = 0; k < NUM_SETTINGS; k++) begin
         if (k * 3 / NUM_SETTINGS == 1) begin
            send_idle_pct  = 77;
            recv_stall_pct = 12;
         end else if (k * 3 / NUM_SETTINGS == 2) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         write_delims(open_set[k], close_set[k]);
         settings_run++;
         phase_start = pending_chars.size() + chars_sent;
         while (pending_chars.size() + chars_sent - phase_start < PHASE_CHARS)
            push_random_list();
         wait_drained();
      end

      // deep nesting saturates, then unbalanced close
      push_run(open_cfg, 300);
      push_run(close_cfg, MAX_DEPTH);
      pending_chars.push_back(CHAR_COMMA);
      pending_chars.push_back(close_cfg);
      pending_chars.push_back(CHAR_NUL);
      wait_drained();
      repeat (8) @(posedge clock);

      $display("%0d characters sent, %0d arguments checked, %0d delimiter settings",
               chars_sent, args_checked, settings_run);
      $display("includes nesting deeper than the depth limit and all idle patterns");
      if (mismatches == 0 && expected_args.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d arguments outstanding", mismatches,
                  expected_args.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/nlas_pkg.sv
hw/rtl/nlas_parse.sv
hw/rtl/nested_list_argument_splitter_core.sv
verif/testbench.sv
